// File: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared codes, state encoding and header word helpers of the heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int ADDR_W = 18;   // byte offsets and sizes, with headroom
	localparam int WORD_W = 16;   // header word: size in words plus free flag
	localparam int USED_W = 17;

	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_RESIZE = 2'd2;
	localparam logic [1:0] ACT_UNDEF  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_SPACE = 3'd1;
	localparam logic [2:0] ST_ZERO     = 3'd2;
	localparam logic [2:0] ST_DBL_FREE = 3'd3;
	localparam logic [2:0] ST_NOTHING  = 3'd4;

	typedef enum logic [14:0] {
		S_INIT    = 15'b000000000000001,
		S_IDLE    = 15'b000000000000010,
		S_FD_RD   = 15'b000000000000100,
		S_FD_EV   = 15'b000000000001000,
		S_NX_RD   = 15'b000000000010000,
		S_NX_EV   = 15'b000000000100000,
		S_AL_RD   = 15'b000000001000000,
		S_AL_EV   = 15'b000000010000000,
		S_WR_HEAD = 15'b000000100000000,
		S_WR_OLD  = 15'b000001000000000,
		S_JN_RD   = 15'b000010000000000,
		S_JN_EV   = 15'b000100000000000,
		S_JN_CHK  = 15'b001000000000000,
		S_JN_NX   = 15'b010000000000000,
		S_OUT     = 15'b100000000000000
	} state_t;

	// pack a byte size (multiple of 4, at most 65536) and a free flag
	function automatic logic [WORD_W-1:0] mk_word(input logic [ADDR_W-1:0] sz,
		input logic fr);
		return {sz[16:2], fr};
	endfunction

	function automatic logic [ADDR_W-1:0] word_size(input logic [WORD_W-1:0] w);
		return {1'b0, w[15:1], 2'b00};
	endfunction

endpackage

// File: hw/rtl/ffha_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] request_bytes;
	logic        has_block;
	logic [15:0] block_offset;
	modport source (output valid, action, request_bytes, has_block, block_offset,
		input ready);
	modport sink (input valid, action, request_bytes, has_block, block_offset,
		output ready);
endinterface

interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] payload_offset;
	logic        moved;
	logic [16:0] used_bytes;
	modport source (output valid, status, payload_offset, moved, used_bytes,
		input ready);
	modport sink (input valid, status, payload_offset, moved, used_bytes,
		output ready);
endinterface

// File: hw/rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap block manager with split and coalesce, headers in one RAM.
// ----------------------------------------------------------------------------
// channel   dir  transaction
// req       in   action, request_bytes, has_block, block_offset
// rsp       out  status, payload_offset, moved, used_bytes
// cfg       in   cfg_wr_en / cfg_wr_data: heap_bytes, rebuilds the heap
//
// one request at a time; a search step is a header RAM read plus evaluate,
// the final merge/count walk reads, latches and checks each block and reads
// one more header per merged pair; a request also passes through accept,
// walk exits, grow probe, header writes and result
// reset or a heap_bytes write passes through S_INIT, which writes the first header
// req.ready is high only in idle; a stalled result holds in its register
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
	parameter int HEAP_MAX_BYTES = 65536,
	parameter int HEADER_BYTES   = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	ffha_req_if.sink           req,
	ffha_rsp_if.source         rsp,
	input  logic               cfg_wr_en,
	input  logic [16:0]        cfg_wr_data
);

	localparam int AW       = ffha_pkg::ADDR_W;
	localparam int WW       = ffha_pkg::WORD_W;
	localparam int HDR      = ((HEADER_BYTES + 3) / 4) * 4;
	localparam int HEAP_LIM = (HEAP_MAX_BYTES > 65536) ? 65536 : HEAP_MAX_BYTES;
	localparam int DEPTH    = HEAP_LIM / 4;
	localparam int IW       = $clog2(DEPTH);

	// header memory: one word per 4-byte heap position
	logic [WW-1:0] mem [DEPTH];
	logic          mem_we;
	logic [IW-1:0] mem_wa, mem_ra;
	logic [WW-1:0] mem_wd, rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	ffha_pkg::state_t state_q, state_d;
	logic [16:0]   heap_q, heap_d;
	logic [AW-1:0] off_q, off_d, need_q, need_d, b_q, b_d, bs_q, bs_d;
	logic [AW-1:0] wa_q, wa_d, head_q, head_d;
	logic [15:0]   boff_q, boff_d, pay_q, pay_d;
	logic [1:0]    act_q, act_d;
	logic          reloc_q, reloc_d, moved_q, moved_d;
	logic [2:0]    status_q, status_d;
	logic [WW-1:0] cur_q, cur_d;
	logic [ffha_pkg::USED_W-1:0] cnt_q, cnt_d;

	// heap end: clamp and round down to 4
	logic [AW-1:0] he, lim;
	assign lim = (AW'(heap_q) > AW'(HEAP_LIM)) ? AW'(HEAP_LIM) : AW'(heap_q);
	assign he  = lim & ~AW'(3);

	// decoded read data and walk sums
	logic [AW-1:0] rs, cs, off_rs, off_cs, off_hdr, nx_b, extra;
	logic          rf, cf;
	assign rs      = ffha_pkg::word_size(rd_q);
	assign rf      = rd_q[0];
	assign cs      = ffha_pkg::word_size(cur_q);
	assign cf      = cur_q[0];
	assign off_rs  = off_q + rs;
	assign off_cs  = off_q + cs;
	assign off_hdr = off_q + AW'(HDR);
	assign nx_b    = b_q + bs_q;
	assign extra   = need_q - bs_q;

	function automatic logic [IW-1:0] idx(input logic [AW-1:0] o);
		return o[IW+1:2];
	endfunction

	always_comb begin
		state_d  = state_q;
		heap_d   = heap_q;
		off_d    = off_q;
		need_d   = need_q;
		b_d      = b_q;
		bs_d     = bs_q;
		wa_d     = wa_q;
		head_d   = head_q;
		boff_d   = boff_q;
		pay_d    = pay_q;
		act_d    = act_q;
		reloc_d  = reloc_q;
		moved_d  = moved_q;
		status_d = status_q;
		cur_d    = cur_q;
		cnt_d    = cnt_q;
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = '0;
		mem_ra   = '0;

		case (state_q)
			ffha_pkg::S_INIT: begin
				if (he != '0) begin
					mem_we = 1'b1;
					mem_wd = ffha_pkg::mk_word(he, 1'b1);
				end
				state_d = ffha_pkg::S_IDLE;
			end
			ffha_pkg::S_IDLE: begin
				if (req.valid) begin
					act_d    = req.action;
					need_d   = ((AW'(req.request_bytes) + AW'(3)) & ~AW'(3)) + AW'(HDR);
					boff_d   = req.block_offset;
					status_d = ffha_pkg::ST_NOTHING;
					pay_d    = '0;
					moved_d  = 1'b0;
					reloc_d  = 1'b0;
					off_d    = '0;
					cnt_d    = '0;
					state_d  = ffha_pkg::S_JN_RD;
					case (req.action)
						ffha_pkg::ACT_ALLOC: begin
							if (req.request_bytes == '0) status_d = ffha_pkg::ST_ZERO;
							else state_d = ffha_pkg::S_AL_RD;
						end
						ffha_pkg::ACT_FREE: begin
							if (req.has_block) state_d = ffha_pkg::S_FD_RD;
						end
						ffha_pkg::ACT_RESIZE: begin
							if (req.request_bytes == '0) status_d = ffha_pkg::ST_ZERO;
							else if (!req.has_block) state_d = ffha_pkg::S_AL_RD;
							else state_d = ffha_pkg::S_FD_RD;
						end
						default: state_d = ffha_pkg::S_JN_RD;
					endcase
				end
			end
			// walk the list for the block whose payload is block_offset
			ffha_pkg::S_FD_RD: begin
				if (off_q >= he) begin
					off_d   = '0;
					state_d = ffha_pkg::S_JN_RD;
				end else begin
					mem_ra  = idx(off_q);
					state_d = ffha_pkg::S_FD_EV;
				end
			end
			ffha_pkg::S_FD_EV: begin
				if (off_hdr == AW'(boff_q)) begin
					b_d     = off_q;
					bs_d    = rs;
					off_d   = '0;
					state_d = ffha_pkg::S_JN_RD;
					if (act_q == ffha_pkg::ACT_FREE) begin
						if (rf) begin
							status_d = ffha_pkg::ST_DBL_FREE;
						end else begin
							mem_we   = 1'b1;
							mem_wa   = idx(off_q);
							mem_wd   = ffha_pkg::mk_word(rs, 1'b1);
							status_d = ffha_pkg::ST_OK;
						end
					end else if (!rf) begin
						if (need_q <= rs) begin
							// shrink in place, split only if the spare part holds a header
							status_d = ffha_pkg::ST_OK;
							pay_d    = off_hdr[15:0];
							if (rs - need_q >= AW'(HDR)) begin
								mem_we  = 1'b1;
								mem_wa  = idx(off_q + need_q);
								mem_wd  = ffha_pkg::mk_word(rs - need_q, 1'b1);
								wa_d    = off_q;
								head_d  = need_q;
								state_d = ffha_pkg::S_WR_HEAD;
							end
						end else if (off_rs < he) begin
							state_d = ffha_pkg::S_NX_RD;
						end else begin
							reloc_d = 1'b1;
							state_d = ffha_pkg::S_AL_RD;
						end
					end
				end else if (rs == '0) begin
					off_d   = '0;
					state_d = ffha_pkg::S_JN_RD;
				end else begin
					off_d   = off_rs;
					state_d = ffha_pkg::S_FD_RD;
				end
			end
			// try to grow into the following block
			ffha_pkg::S_NX_RD: begin
				mem_ra  = idx(nx_b);
				state_d = ffha_pkg::S_NX_EV;
			end
			ffha_pkg::S_NX_EV: begin
				if (rf && rs >= extra) begin
					status_d = ffha_pkg::ST_OK;
					pay_d    = 16'(b_q + AW'(HDR));
					if (rs - extra >= AW'(HDR)) begin
						mem_we  = 1'b1;
						mem_wa  = idx(nx_b + extra);
						mem_wd  = ffha_pkg::mk_word(rs - extra, 1'b1);
						wa_d    = b_q;
						head_d  = need_q;
						state_d = ffha_pkg::S_WR_HEAD;
					end else begin
						mem_we  = 1'b1;
						mem_wa  = idx(b_q);
						mem_wd  = ffha_pkg::mk_word(bs_q + rs, 1'b0);
						off_d   = '0;
						state_d = ffha_pkg::S_JN_RD;
					end
				end else begin
					reloc_d = 1'b1;
					off_d   = '0;
					state_d = ffha_pkg::S_AL_RD;
				end
			end
			// first-fit search
			ffha_pkg::S_AL_RD: begin
				if (off_q >= he) begin
					status_d = ffha_pkg::ST_NO_SPACE;
					off_d    = '0;
					state_d  = ffha_pkg::S_JN_RD;
				end else begin
					mem_ra  = idx(off_q);
					state_d = ffha_pkg::S_AL_EV;
				end
			end
			ffha_pkg::S_AL_EV: begin
				if (rs == '0) begin
					status_d = ffha_pkg::ST_NO_SPACE;
					off_d    = '0;
					state_d  = ffha_pkg::S_JN_RD;
				end else if (rf && (rs == need_q || rs >= need_q + AW'(HDR))) begin
					if (rs > need_q) begin
						mem_we = 1'b1;
						mem_wa = idx(off_q + need_q);
						mem_wd = ffha_pkg::mk_word(rs - need_q, 1'b1);
					end
					wa_d     = off_q;
					head_d   = need_q;
					status_d = ffha_pkg::ST_OK;
					pay_d    = off_hdr[15:0];
					moved_d  = reloc_q;
					state_d  = ffha_pkg::S_WR_HEAD;
				end else begin
					off_d   = off_rs;
					state_d = ffha_pkg::S_AL_RD;
				end
			end
			ffha_pkg::S_WR_HEAD: begin
				mem_we = 1'b1;
				mem_wa = idx(wa_q);
				mem_wd = ffha_pkg::mk_word(head_q, 1'b0);
				off_d  = '0;
				if (reloc_q) state_d = ffha_pkg::S_WR_OLD;
				else state_d = ffha_pkg::S_JN_RD;
			end
			// relocation done: release the old block
			ffha_pkg::S_WR_OLD: begin
				mem_we  = 1'b1;
				mem_wa  = idx(b_q);
				mem_wd  = ffha_pkg::mk_word(bs_q, 1'b1);
				state_d = ffha_pkg::S_JN_RD;
			end
			// final walk: merge free neighbors and sum allocated sizes
			ffha_pkg::S_JN_RD: begin
				if (off_q >= he) begin
					state_d = ffha_pkg::S_OUT;
				end else begin
					mem_ra  = idx(off_q);
					state_d = ffha_pkg::S_JN_EV;
				end
			end
			ffha_pkg::S_JN_EV: begin
				cur_d   = rd_q;
				state_d = ffha_pkg::S_JN_CHK;
			end
			ffha_pkg::S_JN_CHK: begin
				if (cs == '0) begin
					state_d = ffha_pkg::S_OUT;
				end else if (off_cs < he && cf) begin
					mem_ra  = idx(off_cs);
					state_d = ffha_pkg::S_JN_NX;
				end else begin
					if (!cf) cnt_d = cnt_q + cs[ffha_pkg::USED_W-1:0];
					off_d   = off_cs;
					state_d = ffha_pkg::S_JN_RD;
				end
			end
			ffha_pkg::S_JN_NX: begin
				if (rf && rs != '0) begin
					cur_d   = ffha_pkg::mk_word(cs + rs, 1'b1);
					mem_we  = 1'b1;
					mem_wa  = idx(off_q);
					mem_wd  = ffha_pkg::mk_word(cs + rs, 1'b1);
					state_d = ffha_pkg::S_JN_CHK;
				end else begin
					off_d   = off_cs;
					state_d = ffha_pkg::S_JN_RD;
				end
			end
			ffha_pkg::S_OUT: begin
				if (rsp.ready) state_d = ffha_pkg::S_IDLE;
			end
			default: state_d = ffha_pkg::S_INIT;
		endcase

		// heap size write rebuilds the heap
		if (cfg_wr_en) begin
			heap_d  = cfg_wr_data;
			state_d = ffha_pkg::S_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_INIT;
			heap_q  <= 17'h10000;
		end else begin
			state_q <= state_d;
			heap_q  <= heap_d;
		end
	end

	always_ff @(posedge clk) begin
		off_q    <= off_d;
		need_q   <= need_d;
		b_q      <= b_d;
		bs_q     <= bs_d;
		wa_q     <= wa_d;
		head_q   <= head_d;
		boff_q   <= boff_d;
		pay_q    <= pay_d;
		act_q    <= act_d;
		reloc_q  <= reloc_d;
		moved_q  <= moved_d;
		status_q <= status_d;
		cur_q    <= cur_d;
		cnt_q    <= cnt_d;
	end

	assign req.ready          = (state_q == ffha_pkg::S_IDLE);
	assign rsp.valid          = (state_q == ffha_pkg::S_OUT);
	assign rsp.status         = status_q;
	assign rsp.payload_offset = pay_q;
	assign rsp.moved          = moved_q;
	assign rsp.used_bytes     = cnt_q;

endmodule

// File: hw/rtl/ffha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] payload_offset,
	input logic        moved
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request taken while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready stayed high after accepting a request");

	a_moved_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && moved) |-> (status == ffha_pkg::ST_OK))
		else $error("moved flagged on a failed result");

	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ffha_pkg::ST_OK) |-> (payload_offset == 16'd0))
		else $error("payload offset nonzero on a failed result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)))
		else $error("stalled result changed");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (req.valid),
	.in_ready       (req.ready),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.status         (rsp.status),
	.payload_offset (rsp.payload_offset),
	.moved          (rsp.moved)
);
